>>> rtl/core/census_transform_window_defines.svh
// Assertion macros for the census window checker.
`ifndef CENSUS_TRANSFORM_WINDOW_DEFINES_SVH
`define CENSUS_TRANSFORM_WINDOW_DEFINES_SVH

// Checked on every clock, skipped while reset is high
`define CTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock, reset included
`define CTW_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/ctw_pkg.sv
package ctw_pkg;

   // default size limits
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;

   // pixel and window geometry
   localparam int PIX_W    = 8;
   localparam int LINES    = 8;
   localparam int SLOT_W   = 3;
   localparam int WROWS    = 9;
   localparam int WCOLS    = 7;
   localparam int CENSUS_W = 63;

   // field widths
   localparam int ROW_OUT_W    = 12;
   localparam int COL_OUT_W    = 11;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE   = 2'd2;

   // window modes
   localparam logic MODE_5X5 = 1'b0;
   localparam logic MODE_9X7 = 1'b1;

   // register reset values
   localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT = 13'd480;
   localparam logic                    RST_MODE   = MODE_9X7;

   // 9x7 window: guard, first emitting row/col, centre offsets
   localparam int M1_GUARD_W = 9;
   localparam int M1_GUARD_H = 7;
   localparam int M1_ROW_MIN = 8;
   localparam int M1_COL_MIN = 6;
   localparam int M1_ROW_OFF = 4;
   localparam int M1_COL_OFF = 3;
   localparam int M1_CTR_ROW = 4;
   localparam int M1_CTR_COL = 3;

   // 5x5 window sits in the bottom-right corner of the 9x7 register
   localparam int M0_SIZE    = 5;
   localparam int M0_GUARD   = 5;
   localparam int M0_ROW_MIN = 4;
   localparam int M0_COL_MIN = 4;
   localparam int M0_ROW_OFF = 2;
   localparam int M0_COL_OFF = 2;
   localparam int M0_ROW0    = 4;
   localparam int M0_COL0    = 2;
   localparam int M0_CTR_ROW = 6;
   localparam int M0_CTR_COL = 4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WROWS-1:0] column_type;
   typedef pix_type [LINES-1:0] line_word_type;

   // zero acts as one, oversize saturates
   function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
      int unsigned res;
      if (v == 0) begin
         res = 1;
      end else if (v > maxv) begin
         res = maxv;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/census_transform_window.sv
// Census transform over a streamed grey image, 5x5 or 9 rows by 7 columns.
// req_*: one 8-bit pixel per item in raster order; row and column are counted
//   here and wrap after image_width pixels and image_height rows.
// rsp_*: one item per pixel whose window centre lies in the interior: the
//   census word (top-left neighbor in the MSB) and the centre coordinates.
//   Border centres and images at or below the size guard give no item.
// csr_*: APB-style port. 0x0 image_width, 0x4 image_height, 0x8 window_mode.
//   Write only while no pixel is in flight.
// Throughput: one pixel per clock while the output register is not stalled. Each
//   pixel passes the line store read, the window shift and the compare before rsp_valid rises.
// The line store is a single-port column memory, 8 lines by MAX_WIDTH, read
//   and written at the same column in the accepting cycle.
// Stall: the whole pipe advances only when the output register is empty or
//   being taken, so req_ready = !rsp_valid | rsp_ready; nothing is dropped.
// Reset: counters go to row 0, column 0, registers take 640 x 480 in 9x7 mode,
//   the pipe empties. Line store contents are not cleared and never need it.
module census_transform_window #(
   parameter int MAX_WIDTH  = ctw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ctw_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ctw_pkg::PIX_W-1:0]            req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ctw_pkg::CENSUS_W-1:0]         rsp_census_value,
   output logic [ctw_pkg::ROW_OUT_W-1:0]        rsp_center_row,
   output logic [ctw_pkg::COL_OUT_W-1:0]        rsp_center_col,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ctw_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ctw_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ctw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // configuration
   logic [ctw_pkg::WIDTH_REG_W-1:0]  width_reg_ff, width_reg_in;
   logic [ctw_pkg::HEIGHT_REG_W-1:0] height_reg_ff, height_reg_in;
   logic                             mode_ff, mode_in;
   logic [CW:0]                      eff_w_ff, eff_w_in;
   logic [RW:0]                      eff_h_ff, eff_h_in;
   logic                             csr_wr;

   // counters
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   logic          col_wrap;
   logic [CW-1:0] cur_c;
   logic [RW:0]   row_inc;
   logic [RW-1:0] cur_r;
   logic [CW:0]   next_c;
   logic [RW:0]   next_r;
   logic          emit_ok;
   logic [ctw_pkg::ROW_OUT_W-1:0] cur_cr;
   logic [ctw_pkg::COL_OUT_W-1:0] cur_cc;

   // pipe control
   logic advance, accept;
   logic v1_ff, v2_ff, rsp_valid_ff;

   // stage 1 payload
   ctw_pkg::pix_type                  px1_ff;
   logic [ctw_pkg::SLOT_W-1:0]        slot1_ff;
   logic                              ok1_ff;
   logic [ctw_pkg::ROW_OUT_W-1:0]     cr1_ff;
   logic [ctw_pkg::COL_OUT_W-1:0]     cc1_ff;
   ctw_pkg::line_word_type            line_rd;
   ctw_pkg::column_type               new_col;

   // stage 2 payload and window
   logic                              ok2_ff;
   logic [ctw_pkg::ROW_OUT_W-1:0]     cr2_ff;
   logic [ctw_pkg::COL_OUT_W-1:0]     cc2_ff;
   ctw_pkg::column_type               cell_col [ctw_pkg::WCOLS+1];
   logic [ctw_pkg::WROWS-1:0]         cell_lt [ctw_pkg::WCOLS];
   ctw_pkg::pix_type                  centre;
   logic [ctw_pkg::CENSUS_W-1:0]      census;

   // output register
   logic [ctw_pkg::CENSUS_W-1:0]      census_ff;
   logic [ctw_pkg::ROW_OUT_W-1:0]     out_row_ff;
   logic [ctw_pkg::COL_OUT_W-1:0]     out_col_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign accept  = req_valid && advance;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   // register writes, effective sizes worked out once per write
   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      mode_in       = mode_ff;
      eff_w_in      = eff_w_ff;
      eff_h_in      = eff_h_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            ctw_pkg::REG_WIDTH: begin
               width_reg_in = csr_pwdata[ctw_pkg::WIDTH_REG_W-1:0];
               eff_w_in = (CW+1)'(ctw_pkg::eff_size(
                  32'(csr_pwdata[ctw_pkg::WIDTH_REG_W-1:0]), MAX_WIDTH));
            end
            ctw_pkg::REG_HEIGHT: begin
               height_reg_in = csr_pwdata[ctw_pkg::HEIGHT_REG_W-1:0];
               eff_h_in = (RW+1)'(ctw_pkg::eff_size(
                  32'(csr_pwdata[ctw_pkg::HEIGHT_REG_W-1:0]), MAX_HEIGHT));
            end
            ctw_pkg::REG_MODE: begin
               mode_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         ctw_pkg::REG_WIDTH:  csr_prdata = ctw_pkg::CSR_DATA_W'(width_reg_ff);
         ctw_pkg::REG_HEIGHT: csr_prdata = ctw_pkg::CSR_DATA_W'(height_reg_ff);
         ctw_pkg::REG_MODE:   csr_prdata = ctw_pkg::CSR_DATA_W'(mode_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // position of this pixel: wrap first in case the size changed, then step
   always_comb begin
      col_wrap = {1'b0, col_cnt_ff} >= eff_w_ff;
      cur_c    = col_wrap ? '0 : col_cnt_ff;
      row_inc  = {1'b0, row_cnt_ff} + (RW+1)'(col_wrap);
      cur_r    = (row_inc >= eff_h_ff) ? '0 : row_inc[RW-1:0];
      next_c   = {1'b0, cur_c} + (CW+1)'(1);
      next_r   = {1'b0, cur_r} + (RW+1)'(1);
      if (next_c >= eff_w_ff) begin
         col_cnt_in = '0;
         row_cnt_in = (next_r >= eff_h_ff) ? '0 : next_r[RW-1:0];
      end else begin
         col_cnt_in = next_c[CW-1:0];
         row_cnt_in = cur_r;
      end
   end

   // emit decision and centre coordinates for this pixel
   always_comb begin
      if (mode_ff == ctw_pkg::MODE_9X7) begin
         emit_ok = (eff_w_ff > (CW+1)'(ctw_pkg::M1_GUARD_W))
                && (eff_h_ff > (RW+1)'(ctw_pkg::M1_GUARD_H))
                && (cur_r >= RW'(ctw_pkg::M1_ROW_MIN))
                && (cur_c >= CW'(ctw_pkg::M1_COL_MIN));
         cur_cr = ctw_pkg::ROW_OUT_W'(32'(cur_r) - 32'(ctw_pkg::M1_ROW_OFF));
         cur_cc = ctw_pkg::COL_OUT_W'(32'(cur_c) - 32'(ctw_pkg::M1_COL_OFF));
      end else begin
         emit_ok = (eff_w_ff > (CW+1)'(ctw_pkg::M0_GUARD))
                && (eff_h_ff > (RW+1)'(ctw_pkg::M0_GUARD))
                && (cur_r >= RW'(ctw_pkg::M0_ROW_MIN))
                && (cur_c >= CW'(ctw_pkg::M0_COL_MIN));
         cur_cr = ctw_pkg::ROW_OUT_W'(32'(cur_r) - 32'(ctw_pkg::M0_ROW_OFF));
         cur_cc = ctw_pkg::COL_OUT_W'(32'(cur_c) - 32'(ctw_pkg::M0_COL_OFF));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= ctw_pkg::RST_WIDTH;
         height_reg_ff <= ctw_pkg::RST_HEIGHT;
         mode_ff       <= ctw_pkg::RST_MODE;
         eff_w_ff      <= (CW+1)'(ctw_pkg::eff_size(32'(ctw_pkg::RST_WIDTH), MAX_WIDTH));
         eff_h_ff      <= (RW+1)'(ctw_pkg::eff_size(32'(ctw_pkg::RST_HEIGHT), MAX_HEIGHT));
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         mode_ff       <= mode_in;
         eff_w_ff      <= eff_w_in;
         eff_h_ff      <= eff_h_in;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
         if (advance) begin
            v1_ff        <= accept;
            v2_ff        <= v1_ff;
            rsp_valid_ff <= v2_ff && ok2_ff;
         end
      end
   end

   // line store: read rows r-8..r-1 at this column, write this pixel
   ctw_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .addr    (cur_c),
      .slot    (cur_r[ctw_pkg::SLOT_W-1:0]),
      .pixel   (req_pixel),
      .rd_data (line_rd)
   );

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff   <= req_pixel;
         slot1_ff <= cur_r[ctw_pkg::SLOT_W-1:0];
         ok1_ff   <= emit_ok;
         cr1_ff   <= cur_cr;
         cc1_ff   <= cur_cc;
      end
   end

   // rotate the line slots so the oldest row comes first, new pixel at the bottom
   always_comb begin
      for (int k = 0; k < ctw_pkg::LINES; k++) begin
         new_col[k] = line_rd[slot1_ff + ctw_pkg::SLOT_W'(k)];
      end
      new_col[ctw_pkg::WROWS-1] = px1_ff;
   end

   assign cell_col[ctw_pkg::WCOLS] = new_col;

   // window: a row of column cells, shifting left once per pixel
   for (genvar j = 0; j < ctw_pkg::WCOLS; j++) begin : g_cell
      ctw_window_cell u_cell (
         .clock    (clock),
         .shift_en (advance && v1_ff),
         .col_in   (cell_col[j+1]),
         .centre   (centre),
         .col_out  (cell_col[j]),
         .lt       (cell_lt[j])
      );
   end

   // stage 2 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         ok2_ff <= ok1_ff;
         cr2_ff <= cr1_ff;
         cc2_ff <= cc1_ff;
      end
   end

   // centre pixel of the selected window
   assign centre = (mode_ff == ctw_pkg::MODE_9X7)
                 ? cell_col[ctw_pkg::M1_CTR_COL][ctw_pkg::M1_CTR_ROW]
                 : cell_col[ctw_pkg::M0_CTR_COL][ctw_pkg::M0_CTR_ROW];

   // gather the cell bits row-major, top-left in the MSB
   always_comb begin
      census = '0;
      if (mode_ff == ctw_pkg::MODE_9X7) begin
         for (int k = 0; k < ctw_pkg::WROWS; k++) begin
            for (int j = 0; j < ctw_pkg::WCOLS; j++) begin
               census[ctw_pkg::CENSUS_W-1 - (k*ctw_pkg::WCOLS + j)] = cell_lt[j][k];
            end
         end
      end else begin
         for (int k = 0; k < ctw_pkg::M0_SIZE; k++) begin
            for (int j = 0; j < ctw_pkg::M0_SIZE; j++) begin
               census[ctw_pkg::M0_SIZE*ctw_pkg::M0_SIZE-1 - (k*ctw_pkg::M0_SIZE + j)] =
                  cell_lt[ctw_pkg::M0_COL0 + j][ctw_pkg::M0_ROW0 + k];
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance && v2_ff && ok2_ff) begin
         census_ff  <= census;
         out_row_ff <= cr2_ff;
         out_col_ff <= cc2_ff;
      end
   end

   assign req_ready        = advance;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_census_value = census_ff;
   assign rsp_center_row   = out_row_ff;
   assign rsp_center_col   = out_col_ff;

endmodule

>>> rtl/core/ctw_line_store.sv
module ctw_line_store #(
   parameter int MAX_WIDTH = ctw_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]        addr,
   input  logic [ctw_pkg::SLOT_W-1:0]          slot,
   input  ctw_pkg::pix_type                    pixel,
   output ctw_pkg::line_word_type              rd_data
);

   // one word per column, one byte lane per buffered line
   ctw_pkg::line_word_type line_mem [MAX_WIDTH];
   ctw_pkg::line_word_type rd_data_ff;

   // read-before-write: the old column comes out, the new pixel lands in its slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_data_ff <= line_mem[addr];
         line_mem[addr][slot] <= pixel;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ctw_window_cell.sv
module ctw_window_cell (
   input  logic                          clock,
   input  logic                          shift_en,
   input  ctw_pkg::column_type           col_in,
   input  ctw_pkg::pix_type              centre,
   output ctw_pkg::column_type           col_out,
   output logic [ctw_pkg::WROWS-1:0]     lt
);

   ctw_pkg::column_type pix_ff;

   // take the column from the right-hand neighbor
   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= col_in;
      end
   end

   // census bit per row: strictly darker than the centre
   always_comb begin
      for (int k = 0; k < ctw_pkg::WROWS; k++) begin
         lt[k] = pix_ff[k] < centre;
      end
   end

   assign col_out = pix_ff;

endmodule

>>> rtl/core/ctw_checker.sv
`include "census_transform_window_defines.svh"

module ctw_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [ctw_pkg::CENSUS_W-1:0]         rsp_census_value,
   input logic [ctw_pkg::ROW_OUT_W-1:0]        rsp_center_row,
   input logic [ctw_pkg::COL_OUT_W-1:0]        rsp_center_col
);

   // stalled result keeps its valid and payload
   property p_stall_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_census_value)
         && $stable(rsp_center_row) && $stable(rsp_center_col);
   endproperty

   // pipe empties at reset
   `CTW_ASSERT_RESET(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // input is taken exactly when the output register can move
   `CTW_ASSERT(a_ready_follows_out, req_ready == (!rsp_valid || rsp_ready), "req_ready mismatch")

   // stalled result holds
   `CTW_ASSERT(a_stall_hold, p_stall_hold, "stalled result changed")

   // bit 31 is the 9x7 centre and lies above the 5x5 word: always clear
   `CTW_ASSERT(a_centre_bit_clear, rsp_valid |-> !rsp_census_value[31], "centre bit set in census word")

endmodule

bind census_transform_window ctw_checker u_ctw_checker (.*);

>>> tb/ctw_tb_pkg.sv
package ctw_tb_pkg;
   import ctw_pkg::*;

   // one census word with its centre coordinates
   typedef struct packed {
      logic [CENSUS_W-1:0]  word;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
   } census_result_type;

   // Tracks image position, line store and window, and holds the census words
   // still owed by the block.
   class census_tracker;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      logic                    mode_reg;

      logic [PIX_W-1:0] lines [LINES][DEF_MAX_WIDTH];
      logic [PIX_W-1:0] win [WROWS][WCOLS];
      int unsigned      row_pos;
      int unsigned      col_pos;

      census_result_type owed_q [$];
      int unsigned       errors;
      int unsigned       matched;

      function new();
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         mode_reg   = RST_MODE;
         foreach (lines[i, j]) lines[i][j] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         row_pos = 0;
         col_pos = 0;
         errors  = 0;
         matched = 0;
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_WIDTH:  width_reg = value[WIDTH_REG_W-1:0];
            REG_HEIGHT: height_reg = value[HEIGHT_REG_W-1:0];
            REG_MODE:   mode_reg = value[0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(input logic [1:0] idx);
         logic [CSR_DATA_W-1:0] v;
         v = '0;
         case (idx)
            REG_WIDTH:  v[WIDTH_REG_W-1:0] = width_reg;
            REG_HEIGHT: v[HEIGHT_REG_W-1:0] = height_reg;
            REG_MODE:   v[0] = mode_reg;
            default: ;
         endcase
         return v;
      endfunction

      // zero acts as one, oversize clamps to the line store size
      function int unsigned active_width();
         if (width_reg == 0) return 1;
         return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      endfunction

      function int unsigned active_height();
         if (height_reg == 0) return 1;
         return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
      endfunction

      function int unsigned frame_pixels();
         return active_width() * active_height();
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      // Advance the image by one accepted pixel item.
      function void take_pixel(input logic [PIX_W-1:0] px);
         int unsigned w, h, r, c;
         int unsigned top, left, nrow, ncol;
         logic [PIX_W-1:0] fresh [WROWS];
         logic [PIX_W-1:0] ctr;
         logic [CENSUS_W-1:0] word;
         bit emit;
         census_result_type res;
         w = active_width();
         h = active_height();

         // wrap first: a register change may leave the counters out of range
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;

         // column of the eight stored lines plus the new pixel
         for (int k = 0; k < LINES; k++) fresh[k] = lines[(r + k) % LINES][c];
         fresh[LINES] = px;
         lines[r % LINES][c] = px;

         for (int k = 0; k < WROWS; k++) begin
            for (int j = 0; j < WCOLS - 1; j++) win[k][j] = win[k][j+1];
            win[k][WCOLS-1] = fresh[k];
         end

         if (mode_reg == MODE_9X7) begin
            top  = 0;
            left = 0;
            nrow = WROWS;
            ncol = WCOLS;
            emit = (w > M1_GUARD_W) && (h > M1_GUARD_H) && (r >= M1_ROW_MIN) &&
                   (c >= M1_COL_MIN);
            res.row = ROW_OUT_W'(r - M1_ROW_OFF);
            res.col = COL_OUT_W'(c - M1_COL_OFF);
         end else begin
            // 5x5 sits in the lower right corner of the 9x7 register
            top  = M0_ROW0;
            left = M0_COL0;
            nrow = M0_SIZE;
            ncol = M0_SIZE;
            emit = (w > M0_GUARD) && (h > M0_GUARD) && (r >= M0_ROW_MIN) &&
                   (c >= M0_COL_MIN);
            res.row = ROW_OUT_W'(r - M0_ROW_OFF);
            res.col = COL_OUT_W'(c - M0_COL_OFF);
         end

         if (emit) begin
            ctr  = win[top + nrow / 2][left + ncol / 2];
            word = '0;
            for (int k = 0; k < nrow; k++)
               for (int j = 0; j < ncol; j++)
                  word = {word[CENSUS_W-2:0], (win[top+k][left+j] < ctr)};
            res.word = word;
            owed_q.push_back(res);
         end

         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      // Compare one accepted result item with the oldest owed word.
      function void check_result(input logic [CENSUS_W-1:0] word,
                                 input logic [ROW_OUT_W-1:0] row,
                                 input logic [COL_OUT_W-1:0] col);
         census_result_type exp_res;
         bit bad;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result item word %h row %0d col %0d",
                     $time, word, row, col);
            errors++;
            return;
         end
         exp_res = owed_q.pop_front();
         bad = 1'b0;
         if (word !== exp_res.word) begin
            $display("%0t: census_value expected %h got %h", $time, exp_res.word, word);
            bad = 1'b1;
         end
         if (row !== exp_res.row) begin
            $display("%0t: center_row expected %0d got %0d", $time, exp_res.row, row);
            bad = 1'b1;
         end
         if (col !== exp_res.col) begin
            $display("%0t: center_col expected %0d got %0d", $time, exp_res.col, col);
            bad = 1'b1;
         end
         if (bad) errors++;
         else matched++;
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ctw_pkg::*;
   import ctw_tb_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 140;
   localparam int FILL_WIDTH    = 16;
   localparam int LONG_ROW      = 40;

   typedef enum logic [2:0] {TEX_NOISE, TEX_FLAT, TEX_SPOTS, TEX_LOW, TEX_RAMP} texture_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CENSUS_W-1:0]   rsp_census_value;
   logic [ROW_OUT_W-1:0]  rsp_center_row;
   logic [COL_OUT_W-1:0]  rsp_center_col;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   census_tracker board;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles   = 0;
   int unsigned pixels_sent    = 0;
   int unsigned settings_used  = 0;
   int unsigned csr_errors     = 0;

   census_transform_window dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_census_value (rsp_census_value),
      .rsp_center_row   (rsp_center_row),
      .rsp_center_col   (rsp_center_col),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side: check each accepted item, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_census_value, rsp_center_row, rsp_center_col);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: no item moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results still owed",
                  $time, quiet_cycles, board.pending());
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one pixel item, with random idle cycles ahead of it
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_pixel(px);
      pixels_sent++;
   endtask

   // block must be idle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write, then read back
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_reg(idx, value);

      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== board.reg_value(idx)) begin
         $display("%0t: register %0d readback expected %h got %h",
                  $time, idx, board.reg_value(idx), readback);
         csr_errors++;
      end
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input logic mode);
      drain();
      write_reg(REG_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_MODE, CSR_DATA_W'(mode));
      settings_used++;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input texture_type tex, input int unsigned n,
                                                   input logic [PIX_W-1:0] base);
      case (tex)
         TEX_FLAT:  return base;
         // lone bright spots give an all-darker neighborhood
         TEX_SPOTS: return ($urandom_range(15) == 0) ? 8'hFF : 8'h00;
         // many ties with the centre
         TEX_LOW:   return PIX_W'(base + $urandom_range(2));
         TEX_RAMP:  return PIX_W'(n);
         default:   return PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_run(input int unsigned count, input texture_type tex);
      logic [PIX_W-1:0] base;
      base = PIX_W'($urandom);
      for (int unsigned n = 0; n < count; n++) send_pixel(pick_pixel(tex, n, base));
   endtask

   // random small image setting, now and then at the size guard
   task automatic pick_setting();
      int unsigned w, h, kind;
      logic mode;
      kind = $urandom_range(9);
      mode = $urandom_range(1);
      if (mode == MODE_9X7) begin
         w = $urandom_range(16, 10);
         h = $urandom_range(11, 8);
         if (kind == 0) begin
            if ($urandom_range(1) == 1) w = M1_GUARD_W;
            else h = M1_GUARD_H;
         end else if (kind == 1) begin
            w = M1_GUARD_W + 1;
            h = M1_GUARD_H + 1;
         end
      end else begin
         w = $urandom_range(14, 6);
         h = $urandom_range(10, 6);
         if (kind == 0) begin
            if ($urandom_range(1) == 1) w = M0_GUARD;
            else h = M0_GUARD;
         end else if (kind == 1) begin
            w = M0_GUARD + 1;
            h = M0_GUARD + 1;
         end
      end
      configure(w, h, mode);
   endtask

   initial begin
      int unsigned phase_start, count;
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_pixel   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill pass over every column the small settings use: each line slot
      // gets written, the last row already yields words
      configure(FILL_WIDTH, WROWS, MODE_9X7);
      send_run(board.frame_pixels(), TEX_NOISE);

      // zero size acts as 1x1, no words
      configure(0, 0, MODE_5X5);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      // one pixel per row walks down to row 4
      configure(1, 13'h1FFF, MODE_5X5);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'h80);
      send_pixel(8'h01);
      // widen mid-frame: row 4 now emits at columns 4 and 5
      configure(6, 13'h1FFF, MODE_5X5);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h80);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h01);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      // column past the new width wraps, 9x7 guard holds
      configure(2, 13'h1FFF, MODE_9X7);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      // row past the new height wraps to row 0
      configure(2, 3, MODE_9X7);
      send_pixel(8'hFF);
      send_pixel(8'h00);

      // oversized width and height clamp: a row longer than any small setting,
      // no words yet; the next setting wraps the column
      configure(12'hFFF, 13'h1FFF, MODE_5X5);
      send_run(LONG_ROW, TEX_NOISE);

      // random frames, some cut short, under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 76;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 76;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         phase_start = pixels_sent;
         while (pixels_sent - phase_start < PHASE_ITEMS) begin
            pick_setting();
            count = board.frame_pixels();
            if ($urandom_range(4) == 0) count = $urandom_range(count, 1);
            send_run(count, texture_type'($urandom_range(4)));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Run covered %0d pixel items over %0d register settings: both window modes,",
               pixels_sent, settings_used);
      $display("size guards, zero and oversized sizes, mid-frame changes; %0d words matched",
               board.matched);
      if (board.errors == 0 && csr_errors == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
